@@ sv/pcx_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_pkg
// Shared types and constants of the PCX run-length stream decoder.
// ----------------------------------------------------------------------------
package pcx_pkg;

  // header layout and checks
  localparam logic [7:0] MAKER_ID     = 8'd10;
  localparam logic [7:0] ENC_RLE      = 8'd1;
  localparam logic [6:0] HDR_MAKER    = 7'd0;
  localparam logic [6:0] HDR_ENC      = 7'd2;
  localparam logic [6:0] HDR_XMIN     = 7'd4;
  localparam logic [6:0] HDR_YMIN     = 7'd6;
  localparam logic [6:0] HDR_XMAX     = 7'd8;
  localparam logic [6:0] HDR_YMAX     = 7'd10;
  localparam logic [6:0] HDR_LINE     = 7'd66;
  localparam logic [6:0] HDR_LAST     = 7'd127;

  localparam logic [7:0] RUN_MARK     = 8'd192;
  localparam logic [9:0] PAL_LAST     = 10'd767;

  // command queue between parser and expander
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = CMD_PTR_W + 1;

  // configuration register index
  localparam logic CFG_LOAD_PALETTE = 1'b0;

  typedef enum logic [1:0] {
    KIND_IMAGE   = 2'd0,
    KIND_PALETTE = 2'd1,
    KIND_INFO    = 2'd2,
    KIND_ERROR   = 2'd3
  } pcx_kind_e;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_HDR,
    PH_IMAGE,
    PH_TAG,
    PH_PAL
  } pcx_phase_e;

  typedef struct packed {
    pcx_kind_e   kind;
    logic [7:0]  data;
    logic [31:0] pos;
    logic [5:0]  cnt;
    logic [16:0] width;
    logic [16:0] height;
    logic        last;
  } pcx_cmd_t;

endpackage
`default_nettype wire

@@ sv/pcx_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_front
// Byte parser: checks and reads the header, classifies image bytes into
// literals and runs, tracks the palette; each byte pushes at most one command.
// ----------------------------------------------------------------------------
module pcx_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire  [7:0]         file_byte_i,
  input  wire                file_start_i,
  input  wire                load_palette_i,
  input  wire                full_i,
  output logic               in_stall_o,
  output logic               push_o,
  output pcx_pkg::pcx_cmd_t  cmd_o
);
  import pcx_pkg::*;

  pcx_phase_e  phase_q, phase_d, cur_phase;
  logic [6:0]  hcount_q, hcount_d, off;
  logic [15:0] xl_q, xl_d, yl_q, yl_d, xh_q, xh_d, yh_q, yh_d, lb_q, lb_d;
  logic [16:0] w_q, h_q;
  logic [31:0] size_q;
  logic [32:0] prod;
  logic [31:0] rem_q, rem_d, pos_q, pos_d;
  logic [5:0]  pend_q, pend_d, run_cnt;
  logic        runp_q, runp_d;
  logic [9:0]  pcount_q, pcount_d;
  logic        pal_on_q, pal_on_d;
  logic        accept, run_fit;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign prod       = {17'd0, lb_q} * {16'd0, h_q};
  assign run_fit    = rem_q <= {26'd0, pend_q};
  assign run_cnt    = run_fit ? rem_q[5:0] : pend_q;

  // picture geometry settles long before the header's final byte;
  // a height of 65536 wraps onto the top bit but still counts as positive
  always_ff @(posedge clk_i) begin
    w_q    <= {xh_q[15], xh_q} - {xl_q[15], xl_q} + 17'd1;
    h_q    <= {yh_q[15], yh_q} - {yl_q[15], yl_q} + 17'd1;
    size_q <= ((h_q == 17'h10000) || (!h_q[16] && (h_q != 17'd0))) ?
              prod[31:0] : 32'd0;
  end

  always_comb begin
    phase_d  = phase_q;
    hcount_d = hcount_q;
    xl_d     = xl_q;
    yl_d     = yl_q;
    xh_d     = xh_q;
    yh_d     = yh_q;
    lb_d     = lb_q;
    rem_d    = rem_q;
    pos_d    = pos_q;
    pend_d   = pend_q;
    runp_d   = runp_q;
    pcount_d = pcount_q;
    pal_on_d = pal_on_q;
    cur_phase = phase_q;
    off       = hcount_q;
    push_o       = 1'b0;
    cmd_o.kind   = KIND_IMAGE;
    cmd_o.data   = file_byte_i;
    cmd_o.pos    = pos_q;
    cmd_o.cnt    = 6'd1;
    cmd_o.width  = 17'd0;
    cmd_o.height = 17'd0;
    cmd_o.last   = 1'b0;
    if (accept) begin
      if (file_start_i) begin
        cur_phase = PH_HDR;
        phase_d   = PH_HDR;
        off       = 7'd0;
        pal_on_d  = load_palette_i;
        runp_d    = 1'b0;
        pend_d    = 6'd0;
        pcount_d  = 10'd0;
      end
      case (cur_phase)
        PH_HDR: begin
          hcount_d = off + 7'd1;
          if ((off == HDR_MAKER && file_byte_i != MAKER_ID) ||
              (off == HDR_ENC && file_byte_i != ENC_RLE)) begin
            push_o     = 1'b1;
            cmd_o.kind = KIND_ERROR;
            cmd_o.data = 8'd0;
            cmd_o.pos  = 32'd0;
            cmd_o.last = 1'b1;
            phase_d    = PH_WAIT;
          end else begin
            case (off)
              HDR_XMIN:         xl_d[7:0]  = file_byte_i;
              HDR_XMIN + 7'd1:  xl_d[15:8] = file_byte_i;
              HDR_YMIN:         yl_d[7:0]  = file_byte_i;
              HDR_YMIN + 7'd1:  yl_d[15:8] = file_byte_i;
              HDR_XMAX:         xh_d[7:0]  = file_byte_i;
              HDR_XMAX + 7'd1:  xh_d[15:8] = file_byte_i;
              HDR_YMAX:         yh_d[7:0]  = file_byte_i;
              HDR_YMAX + 7'd1:  yh_d[15:8] = file_byte_i;
              HDR_LINE:         lb_d[7:0]  = file_byte_i;
              HDR_LINE + 7'd1:  lb_d[15:8] = file_byte_i;
              default: ;
            endcase
            if (off == HDR_LAST) begin
              push_o       = 1'b1;
              cmd_o.kind   = KIND_INFO;
              cmd_o.data   = 8'd0;
              cmd_o.pos    = 32'd0;
              cmd_o.width  = w_q;
              cmd_o.height = h_q;
              cmd_o.last   = (size_q == 32'd0) && !pal_on_d;
              phase_d      = (size_q != 32'd0) ? PH_IMAGE : PH_TAG;
              rem_d        = size_q;
              pos_d        = 32'd0;
              runp_d       = 1'b0;
            end
          end
        end
        PH_IMAGE: begin
          if (runp_q) begin
            // value byte of a run: clip at the image end
            runp_d    = 1'b0;
            push_o    = run_cnt != 6'd0;
            cmd_o.cnt = run_cnt;
            cmd_o.last = run_fit && !pal_on_q;
            rem_d     = rem_q - {26'd0, run_cnt};
            pos_d     = pos_q + {26'd0, run_cnt};
            if (run_fit) begin
              phase_d = PH_TAG;
            end
          end else if (file_byte_i < RUN_MARK) begin
            push_o     = 1'b1;
            cmd_o.last = (rem_q == 32'd1) && !pal_on_q;
            rem_d      = rem_q - 32'd1;
            pos_d      = pos_q + 32'd1;
            if (rem_q == 32'd1) begin
              phase_d = PH_TAG;
            end
          end else begin
            pend_d = file_byte_i[5:0];
            runp_d = 1'b1;
          end
        end
        PH_TAG: begin
          pcount_d = 10'd0;
          phase_d  = pal_on_q ? PH_PAL : PH_WAIT;
        end
        PH_PAL: begin
          push_o     = 1'b1;
          cmd_o.kind = KIND_PALETTE;
          cmd_o.data = {2'b00, file_byte_i[7:2]};
          cmd_o.pos  = {22'd0, pcount_q};
          cmd_o.last = pcount_q == PAL_LAST;
          pcount_d   = pcount_q + 10'd1;
          if (pcount_q == PAL_LAST) begin
            phase_d = PH_WAIT;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT;
      hcount_q <= 7'd0;
      xl_q     <= 16'd0;
      yl_q     <= 16'd0;
      xh_q     <= 16'd0;
      yh_q     <= 16'd0;
      lb_q     <= 16'd0;
      rem_q    <= 32'd0;
      pos_q    <= 32'd0;
      pend_q   <= 6'd0;
      runp_q   <= 1'b0;
      pcount_q <= 10'd0;
      pal_on_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      hcount_q <= hcount_d;
      xl_q     <= xl_d;
      yl_q     <= yl_d;
      xh_q     <= xh_d;
      yh_q     <= yh_d;
      lb_q     <= lb_d;
      rem_q    <= rem_d;
      pos_q    <= pos_d;
      pend_q   <= pend_d;
      runp_q   <= runp_d;
      pcount_q <= pcount_d;
      pal_on_q <= pal_on_d;
    end
  end

  // a command never carries an empty run
  a_cmd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> cmd_o.cnt != 6'd0)
    else $error("empty command pushed");

  // the image phase always has bytes left to produce
  a_image_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IMAGE) |-> rem_q != 32'd0)
    else $error("image phase with nothing remaining");

endmodule
`default_nettype wire

@@ sv/pcx_cmd_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_cmd_fifo
// Short command queue between the parser and the expander.
// ----------------------------------------------------------------------------
module pcx_cmd_fifo (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  pcx_pkg::pcx_cmd_t  cmd_i,
  input  wire                pop_i,
  output logic               full_o,
  output logic               head_valid_o,
  output pcx_pkg::pcx_cmd_t  head_o
);
  import pcx_pkg::*;

  pcx_cmd_t               entry_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CMD_CNT_W-1:0]   count_q;
  logic                   do_push, do_pop;

  assign full_o       = count_q == CMD_CNT_W'(CMD_DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_o       = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
      end
      count_q <= count_q + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CMD_CNT_W'(CMD_DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

@@ sv/pcx_expand.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_expand
// Expands queued commands into result beats, one per cycle while the
// receiver does not stall, through an output register.
// ----------------------------------------------------------------------------
module pcx_expand (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                head_valid_i,
  input  pcx_pkg::pcx_cmd_t  head_i,
  output logic               pop_o,
  input  wire                out_stall_i,
  output logic               out_valid_o,
  output logic [1:0]         kind_o,
  output logic [7:0]         data_o,
  output logic [31:0]        position_o,
  output logic [16:0]        width_o,
  output logic [16:0]        height_o,
  output logic               last_o
);
  import pcx_pkg::*;

  logic [5:0]  sub_q, sub_next;
  logic        out_valid_q;
  pcx_kind_e   kind_q;
  logic [7:0]  data_q;
  logic [31:0] pos_q;
  logic [16:0] width_q, height_q;
  logic        last_q;
  logic        load, sub_end;

  assign load     = head_valid_i && (!out_valid_q || !out_stall_i);
  assign sub_next = sub_q + 6'd1;
  assign sub_end  = sub_next == head_i.cnt;
  assign pop_o    = load && sub_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= 6'd0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        sub_q       <= sub_end ? 6'd0 : sub_next;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= head_i.kind;
      data_q   <= head_i.data;
      pos_q    <= head_i.pos + {26'd0, sub_q};
      width_q  <= head_i.width;
      height_q <= head_i.height;
      last_q   <= head_i.last && sub_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign data_o      = data_q;
  assign position_o  = pos_q;
  assign width_o     = width_q;
  assign height_o    = height_q;
  assign last_o      = last_q;

  // a run part-way through still has its command at the head
  a_run_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sub_q != 6'd0) |-> head_valid_i)
    else $error("run in progress without a command");

endmodule
`default_nettype wire

@@ sv/pcx_rle_stream_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_rle_stream_decoder
// PCX file stream decoder: header check, run-length expansion, palette.
//
// Input channel: one file byte per beat (file_byte_i, file_start_i marks the
// first byte of a file and restarts the parser at any time). Output channel:
// one result per beat (kind, data, position, width, height, last).
// Header, literal, tag and palette bytes are taken at one per cycle while
// in_stall_o is low; the expander emits one result per cycle while the
// receiver does not stall, and a run of n bytes yields n results. A
// four-entry command queue lets the parser run ahead of the expander.
// When the receiver stalls, the result holds, the queue fills and
// in_stall_o rises. Reset empties the queue, drops any partly read file and
// sets load_palette to 1; bytes without file_start are then ignored.
// load_palette sits at byte address 0 of the APB port and is sampled at
// the start of each file.
// ----------------------------------------------------------------------------
module pcx_rle_stream_decoder (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  file_byte_i,
  input  wire         file_start_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_o,
  output logic [31:0] position_o,
  output logic [16:0] width_o,
  output logic [16:0] height_o,
  output logic        last_o
);
  import pcx_pkg::*;

  logic     load_palette_q;
  logic     push, pop, full, head_valid;
  pcx_cmd_t cmd, head;
  logic     cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = paddr[2] == CFG_LOAD_PALETTE;
  assign prdata  = cfg_hit ? {31'd0, load_palette_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_palette_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      load_palette_q <= pwdata[0];
    end
  end

  pcx_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .file_byte_i    (file_byte_i),
    .file_start_i   (file_start_i),
    .load_palette_i (load_palette_q),
    .full_i         (full),
    .in_stall_o     (in_stall_o),
    .push_o         (push),
    .cmd_o          (cmd)
  );

  pcx_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  pcx_expand u_expand (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .kind_o       (kind_o),
    .data_o       (data_o),
    .position_o   (position_o),
    .width_o      (width_o),
    .height_o     (height_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PCX run-length stream decoder.
//
// Feeds whole and broken PCX files one byte per beat, predicts every result
// (header info, header errors, image bytes, palette values) from its own
// model of the parser and compares each result field by field. Both channels
// idle and stall at random; one long output hold-off fills the block up.
// ----------------------------------------------------------------------------
module tb;
  import pcx_pkg::*;

  localparam int HOLD_CYCLES   = 200;
  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_BEATS  = 200;
  localparam int PAL_BYTES     = int'(PAL_LAST) + 1;

  typedef struct {
    pcx_kind_e   kind;
    logic [7:0]  data;
    logic [31:0] pos;
    logic [16:0] width;
    logic [16:0] height;
    logic        last;
  } pcx_result_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  file_byte_i  = '0;
  logic        file_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  data_o;
  logic [31:0] position_o;
  logic [16:0] width_o;
  logic [16:0] height_o;
  logic        last_o;

  pcx_rle_stream_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .file_byte_i  (file_byte_i),
    .file_start_i (file_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .data_o       (data_o),
    .position_o   (position_o),
    .width_o      (width_o),
    .height_o     (height_o),
    .last_o       (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // bench state
  pcx_result_t pending_results[$];
  pcx_result_t want;
  int errors       = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int hold_left    = 0;
  bit hold_start   = 1'b0;
  int quiet        = 0;
  int held_cycles  = 0;
  int live_bytes   = 0;
  int files_begun  = 0;
  int n_info       = 0;
  int n_err        = 0;
  int n_img        = 0;
  int n_pal        = 0;

  // decoder model state
  logic       pal_cfg = 1'b1;
  pcx_phase_e stage   = PH_WAIT;
  logic [6:0]  hdr_idx = '0;
  logic [15:0] x_min = '0, y_min = '0, x_max = '0, y_max = '0, line_len = '0;
  logic [31:0] pic_bytes = '0, pic_done = '0;
  logic [5:0]  run_len = '0;
  logic        run_armed = 1'b0;
  logic        pal_active = 1'b0;
  int          pal_idx = 0;

  function automatic void add_result(input pcx_kind_e k, input logic [7:0] d,
                                     input logic [31:0] p, input logic [16:0] w,
                                     input logic [16:0] h, input logic l);
    pcx_result_t r;
    r.kind = k;
    r.data = d;
    r.pos = p;
    r.width = w;
    r.height = h;
    r.last = l;
    pending_results.push_back(r);
  endfunction

  // advance the model by one accepted byte and queue what it should produce
  function automatic void decode_byte(input logic [7:0] b, input logic st);
    int wi, hi;
    int unsigned cnt, rem;
    if (st) begin
      stage = PH_HDR;
      hdr_idx = '0;
      x_min = '0; y_min = '0; x_max = '0; y_max = '0; line_len = '0;
      pic_bytes = '0;
      pic_done = '0;
      run_len = '0;
      run_armed = 1'b0;
      pal_idx = 0;
      pal_active = pal_cfg;
    end
    case (stage)
      PH_HDR: begin
        if ((hdr_idx == HDR_MAKER && b != MAKER_ID) || (hdr_idx == HDR_ENC && b != ENC_RLE)) begin
          add_result(KIND_ERROR, '0, '0, '0, '0, 1'b1);
          stage = PH_WAIT;
          return;
        end
        case (hdr_idx)
          HDR_XMIN:         x_min[7:0]     = b;
          HDR_XMIN + 7'd1:  x_min[15:8]    = b;
          HDR_YMIN:         y_min[7:0]     = b;
          HDR_YMIN + 7'd1:  y_min[15:8]    = b;
          HDR_XMAX:         x_max[7:0]     = b;
          HDR_XMAX + 7'd1:  x_max[15:8]    = b;
          HDR_YMAX:         y_max[7:0]     = b;
          HDR_YMAX + 7'd1:  y_max[15:8]    = b;
          HDR_LINE:         line_len[7:0]  = b;
          HDR_LINE + 7'd1:  line_len[15:8] = b;
          default: ;
        endcase
        if (hdr_idx == HDR_LAST) begin
          wi = int'($signed(x_max)) - int'($signed(x_min)) + 1;
          hi = int'($signed(y_max)) - int'($signed(y_min)) + 1;
          pic_bytes = (hi > 0) ? 32'(line_len) * 32'(hi) : 32'd0;
          pic_done = '0;
          add_result(KIND_INFO, '0, '0, wi[16:0], hi[16:0], pic_bytes == 0 && !pal_active);
          stage = (pic_bytes != 0) ? PH_IMAGE : PH_TAG;
        end else begin
          hdr_idx = hdr_idx + 7'd1;
        end
      end
      PH_IMAGE: begin
        cnt = 0;
        if (run_armed) begin
          // clip the run at the end of the picture
          rem = pic_bytes - pic_done;
          cnt = run_len;
          if (cnt > rem) cnt = rem;
          run_armed = 1'b0;
        end else if (b < RUN_MARK) begin
          cnt = 1;
        end else begin
          run_len = 6'(b - RUN_MARK);
          run_armed = 1'b1;
        end
        repeat (cnt) begin
          add_result(KIND_IMAGE, b, pic_done, '0, '0,
                     (pic_done + 32'd1 == pic_bytes) && !pal_active);
          pic_done++;
        end
        if (!run_armed && pic_done >= pic_bytes) stage = PH_TAG;
      end
      PH_TAG: stage = pal_active ? PH_PAL : PH_WAIT;
      PH_PAL: begin
        add_result(KIND_PALETTE, {2'b00, b[7:2]}, 32'(pal_idx), '0, '0, pal_idx == PAL_LAST);
        pal_idx++;
        if (pal_idx > PAL_LAST) stage = PH_WAIT;
      end
      default: ;
    endcase
  endfunction

  // offer one byte, hold it until taken, then update the model
  task automatic push_byte(input logic [7:0] b, input logic st);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    file_byte_i  <= b;
    file_start_i <= st;
    do @(posedge clk_i); while (in_stall_o);
    if (st || stage != PH_WAIT) live_bytes++;
    if (st) files_begun++;
    decode_byte(b, st);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [31:0] wd, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {CFG_LOAD_PALETTE, 2'b00};
    pwdata  <= wd;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_palette_cfg();
    logic [31:0] rd;
    apb_xfer(1'b0, '0, rd);
    if (rd[0] !== pal_cfg) begin
      $error("load_palette readback: expected %0d, got %0d", pal_cfg, rd[0]);
      errors++;
    end
  endtask

  task automatic write_palette_cfg(input logic en);
    logic [31:0] rd;
    drain_results();
    apb_xfer(1'b1, {31'b0, en}, rd);
    pal_cfg = en;
    check_palette_cfg();
  endtask

  task automatic send_header(input logic [7:0] maker, input logic [7:0] enc,
                             input logic [15:0] xmin, input logic [15:0] ymin,
                             input logic [15:0] xmax, input logic [15:0] ymax,
                             input logic [15:0] line, input int upto);
    logic [7:0] hdr [0:HDR_LAST];
    int i;
    foreach (hdr[j]) hdr[j] = 8'($urandom_range(255));
    hdr[HDR_MAKER]    = maker;
    hdr[HDR_ENC]      = enc;
    hdr[HDR_XMIN]     = xmin[7:0];
    hdr[HDR_XMIN + 1] = xmin[15:8];
    hdr[HDR_YMIN]     = ymin[7:0];
    hdr[HDR_YMIN + 1] = ymin[15:8];
    hdr[HDR_XMAX]     = xmax[7:0];
    hdr[HDR_XMAX + 1] = xmax[15:8];
    hdr[HDR_YMAX]     = ymax[7:0];
    hdr[HDR_YMAX + 1] = ymax[15:8];
    hdr[HDR_LINE]     = line[7:0];
    hdr[HDR_LINE + 1] = line[15:8];
    for (i = 0; i < upto; i++) begin
      // stop once the parser has rejected the file
      if (i != 0 && stage != PH_HDR) break;
      push_byte(hdr[i], i == 0);
    end
  endtask

  task automatic send_picture_header(input int h, input logic [15:0] line, input int upto);
    logic [15:0] ymin;
    ymin = 16'($urandom);
    send_header(MAKER_ID, ENC_RLE, 16'($urandom), ymin, 16'($urandom),
                ymin + 16'(h - 1), line, upto);
  endtask

  task automatic send_image(input int run_pct, input int limit);
    int k;
    k = 0;
    while (stage == PH_IMAGE && k < limit) begin
      if (run_armed)
        push_byte(8'($urandom_range(255)), 1'b0);
      else if ($urandom_range(99) < run_pct)
        push_byte(RUN_MARK + 8'($urandom_range(63)), 1'b0);
      else
        push_byte(8'($urandom_range(191)), 1'b0);
      k++;
    end
  endtask

  task automatic finish_file(input int full_pct);
    int n, i;
    if (stage == PH_TAG) push_byte(8'($urandom_range(255)), 1'b0);
    if (stage == PH_PAL) begin
      n = ($urandom_range(99) < full_pct) ? PAL_BYTES : int'($urandom_range(24));
      for (i = 0; i < n && stage == PH_PAL; i++) push_byte(8'($urandom_range(255)), 1'b0);
    end
    // trailing junk must be dropped
    if (stage == PH_WAIT) repeat ($urandom_range(2)) push_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic random_file(input int full_pct);
    int r, h;
    logic [7:0] bad;
    if (stage == PH_WAIT && $urandom_range(99) < 15)
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)), 1'b0);
    h = ($urandom_range(9) == 0) ? -int'($urandom_range(3)) : int'($urandom_range(1, 5));
    bad = 8'($urandom_range(255));
    r = $urandom_range(99);
    if (r < 65) begin
      send_picture_header(h, ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 10)), 128);
      send_image(30, 1000000);
      finish_file(full_pct);
    end else if (r < 75) begin
      if (bad == MAKER_ID) bad = ~bad;
      send_header(bad, ENC_RLE, '0, '0, '0, '0, '0, 128);
    end else if (r < 82) begin
      if (bad == ENC_RLE) bad = ~bad;
      send_header(MAKER_ID, bad, '0, '0, '0, '0, '0, 128);
    end else if (r < 90) begin
      send_picture_header(h, 16'd4, $urandom_range(1, 127));
    end else begin
      // cut the picture short, possibly inside a run
      send_picture_header(h, 16'd6, 128);
      send_image(50, $urandom_range(5));
    end
  endtask

  task automatic test_bad_header();
    check_palette_cfg();
    push_byte(8'hFF, 1'b0);
    push_byte(MAKER_ID, 1'b0);
    send_header(8'h00, ENC_RLE, '0, '0, '0, '0, '0, 128);
    push_byte(MAKER_ID, 1'b0);
    send_header(8'hFF, ENC_RLE, '0, '0, '0, '0, '0, 128);
    send_header(MAKER_ID, 8'h00, '0, '0, '0, '0, '0, 128);
    send_header(MAKER_ID, 8'hFF, '0, '0, '0, '0, '0, 128);
  endtask

  task automatic test_small_image();
    // literals at both ends, single run, empty run, run of a marker value,
    // then a full-length run clipped at the end of the picture
    logic [7:0] img [] = '{8'h00, 8'hBF, RUN_MARK + 8'd1, 8'hFF, RUN_MARK, 8'hAA,
                           RUN_MARK + 8'd3, RUN_MARK, 8'h55, RUN_MARK + 8'd63, 8'h12,
                           8'h0C, MAKER_ID, 8'hFF};
    write_palette_cfg(1'b0);
    send_header(MAKER_ID, ENC_RLE, 16'd0, 16'd0, 16'd7, 16'd1, 16'd8, 128);
    foreach (img[i]) push_byte(img[i], 1'b0);
  endtask

  task automatic test_empty_image();
    send_header(MAKER_ID, ENC_RLE, 16'h0010, 16'h0005, 16'h0020, 16'h0004, 16'd8, 128);
    push_byte(8'h0C, 1'b0);
    push_byte(8'h33, 1'b0);
    send_header(MAKER_ID, ENC_RLE, 16'h0000, 16'h0005, 16'hFFFF, 16'h0002, 16'hFFFF, 128);
    push_byte(8'h0C, 1'b0);
  endtask

  task automatic test_palette();
    int i;
    write_palette_cfg(1'b1);
    // empty picture: info is not the last result, palette follows
    send_picture_header(0, 16'd5, 128);
    push_byte(8'h0C, 1'b0);
    repeat (5) push_byte(8'($urandom_range(255)), 1'b0);
    send_picture_header(2, 16'd2, 128);
    send_image(30, 1000000);
    push_byte(8'h0C, 1'b0);
    for (i = 0; i < PAL_BYTES; i++) push_byte(8'(i) ^ 8'h5A, 1'b0);
    push_byte(8'hFF, 1'b0);
  endtask

  task automatic test_restart();
    send_picture_header(1, 16'd4, 40);
    // extreme extents and a huge picture, dropped while a run is pending
    send_header(MAKER_ID, ENC_RLE, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 128);
    push_byte(8'h21, 1'b0);
    push_byte(8'hFF, 1'b0);
    send_picture_header(2, 16'd2, 128);
    send_image(30, 1000000);
    push_byte(8'h0C, 1'b0);
    repeat (30) push_byte(8'($urandom_range(255)), 1'b0);
    send_header(8'hFF, ENC_RLE, '0, '0, '0, '0, '0, 128);
  endtask

  task automatic test_backpressure();
    write_palette_cfg(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_picture_header(4, 16'd63, 128);
    hold_start = 1'b1;
    send_image(100, 24);
    drain_results();
    send_image(100, 1000000);
    finish_file(0);
  endtask

  task automatic test_random(input int tx, input int rx, input logic pal, input int full_pct);
    int goal;
    write_palette_cfg(pal);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    goal = live_bytes + RANDOM_BEATS;
    while (live_bytes < goal) random_file(full_pct);
  endtask

  // output stall, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: kind %0d position %0d", kind_o, position_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind_o));
        check_field("data", 32'(want.data), 32'(data_o));
        check_field("position", want.pos, position_o);
        check_field("width", 32'(want.width), 32'(width_o));
        check_field("height", 32'(want.height), 32'(height_o));
        check_field("last", 32'(want.last), 32'(last_o));
        case (want.kind)
          KIND_IMAGE:   n_img++;
          KIND_PALETTE: n_pal++;
          KIND_INFO:    n_info++;
          default:      n_err++;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (in_valid_i && in_stall_o) held_cycles++;
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $error("no beat on either channel for %0d cycles", QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 27;
    rx_idle_pct = 70;
    test_bad_header();
    test_small_image();
    test_empty_image();
    test_palette();
    test_restart();
    test_random(27, 70, 1'b0, 0);
    test_random(70, 27, 1'b1, 30);
    test_backpressure();
    test_random(0, 0, 1'b0, 0);
    drain_results();
    $display("Covered %0d file starts and %0d live input beats; input held back %0d cycles.",
             files_begun, live_bytes, held_cycles);
    $display("Checked %0d header infos, %0d header errors, %0d image bytes, %0d palette values.",
             n_info, n_err, n_img, n_pal);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
